// ===== hw/rtl/ktb_pkg.sv =====
// Shared types, key codes and lookup tables for the key event to terminal bytes block.
package ktb_pkg;

    localparam int MAX_RESULTS = 6;
    localparam int ESC_LEN_MAX = 5;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TERM = 2'd1;
    localparam logic [1:0] KIND_WIN  = 2'd2;

    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] SPACE_BYTE = 8'd32;

    localparam logic [9:0] KEY_LSHIFT = 10'd42;
    localparam logic [9:0] KEY_RSHIFT = 10'd54;
    localparam logic [9:0] KEY_LALT   = 10'd56;
    localparam logic [9:0] KEY_RALT   = 10'd100;
    localparam logic [9:0] KEY_LCTRL  = 10'd29;
    localparam logic [9:0] KEY_RCTRL  = 10'd97;
    localparam logic [9:0] KEY_CAPS   = 10'd58;
    localparam logic [9:0] KEY_SUPER  = 10'd125;
    localparam logic [9:0] KEY_TAB    = 10'd15;
    localparam logic [9:0] KEY_SPACE  = 10'd57;
    localparam logic [9:0] KEY_MAP_LAST = 10'd53;
    localparam logic [9:0] KEY_DIGIT1 = 10'd2;

    localparam logic [3:0] TERM_COUNT_RESET = 4'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] term;
        logic [2:0] act;
        logic       shf;
    } result_t;

    typedef struct packed {
        logic [2:0]                   cnt;
        result_t [MAX_RESULTS-1:0]    entries;
    } burst_t;

    typedef struct packed {
        logic [2:0]                   len;
        logic [ESC_LEN_MAX-1:0][7:0]  bytes;
    } esc_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] act;
    } win_t;

    localparam logic [7:0] PLAIN_MAP [0:53] = '{
        8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd127, 8'd9,
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd13, 8'd0,
        "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'd96, 8'd0, 8'h5C,
        "z", "x", "c", "v", "b", "n", "m", ",", ".", "/"
    };

    localparam logic [7:0] SHIFT_MAP [0:53] = '{
        8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd127, 8'd9,
        "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd13, 8'd0,
        "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'd0, "|",
        "Z", "X", "C", "V", "B", "N", "M", "<", ">", 8'h3F
    };

    function automatic esc_t esc_seq(input logic [9:0] code);
        esc_t r;
        r = '0;
        case (code)
            10'd59:  begin r.len = 3'd4; r.bytes = {8'd0, "A", "[", "[", ESC_BYTE}; end
            10'd60:  begin r.len = 3'd4; r.bytes = {8'd0, "B", "[", "[", ESC_BYTE}; end
            10'd61:  begin r.len = 3'd4; r.bytes = {8'd0, "C", "[", "[", ESC_BYTE}; end
            10'd62:  begin r.len = 3'd4; r.bytes = {8'd0, "D", "[", "[", ESC_BYTE}; end
            10'd63:  begin r.len = 3'd4; r.bytes = {8'd0, "E", "[", "[", ESC_BYTE}; end
            10'd64:  begin r.len = 3'd5; r.bytes = {"~", "7", "1", "[", ESC_BYTE}; end
            10'd65:  begin r.len = 3'd5; r.bytes = {"~", "8", "1", "[", ESC_BYTE}; end
            10'd66:  begin r.len = 3'd5; r.bytes = {"~", "9", "1", "[", ESC_BYTE}; end
            10'd67:  begin r.len = 3'd5; r.bytes = {"~", "0", "2", "[", ESC_BYTE}; end
            10'd68:  begin r.len = 3'd5; r.bytes = {"~", "1", "2", "[", ESC_BYTE}; end
            10'd87:  begin r.len = 3'd5; r.bytes = {"~", "3", "2", "[", ESC_BYTE}; end
            10'd88:  begin r.len = 3'd5; r.bytes = {"~", "4", "2", "[", ESC_BYTE}; end
            10'd102: begin r.len = 3'd3; r.bytes = {8'd0, 8'd0, "H", "[", ESC_BYTE}; end
            10'd103: begin r.len = 3'd3; r.bytes = {8'd0, 8'd0, "A", "[", ESC_BYTE}; end
            10'd104: begin r.len = 3'd4; r.bytes = {8'd0, "~", "5", "[", ESC_BYTE}; end
            10'd105: begin r.len = 3'd3; r.bytes = {8'd0, 8'd0, "D", "[", ESC_BYTE}; end
            10'd106: begin r.len = 3'd3; r.bytes = {8'd0, 8'd0, "C", "[", ESC_BYTE}; end
            10'd107: begin r.len = 3'd3; r.bytes = {8'd0, 8'd0, "F", "[", ESC_BYTE}; end
            10'd108: begin r.len = 3'd3; r.bytes = {8'd0, 8'd0, "B", "[", ESC_BYTE}; end
            10'd109: begin r.len = 3'd4; r.bytes = {8'd0, "~", "6", "[", ESC_BYTE}; end
            10'd111: begin r.len = 3'd4; r.bytes = {8'd0, 8'd8, "C", "[", ESC_BYTE}; end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic win_t win_action(input logic [9:0] code);
        win_t r;
        r = '0;
        case (code)
            10'd9:           r = '{hit: 1'b1, act: 3'd0};
            10'd10:          r = '{hit: 1'b1, act: 3'd1};
            10'd11:          r = '{hit: 1'b1, act: 3'd2};
            10'd17, 10'd103: r = '{hit: 1'b1, act: 3'd3};
            10'd30, 10'd105: r = '{hit: 1'b1, act: 3'd4};
            10'd31, 10'd108: r = '{hit: 1'b1, act: 3'd5};
            10'd32, 10'd106: r = '{hit: 1'b1, act: 3'd6};
            default:         r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/ktb_decode.sv =====
// Modifier tracking and per-event decode into a burst of results.
module ktb_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic            is_key_event,
    input  logic [9:0]      key_code,
    input  logic [1:0]      key_value,
    input  logic [3:0]      term_count,
    output ktb_pkg::burst_t burst
);
    import ktb_pkg::*;

    logic shift_reg, alt_reg, ctrl_reg, caps_reg, super_reg, disabled_reg;
    logic shift_next, alt_next, ctrl_next, caps_next, super_next, disabled_next;

    logic                       down;
    logic                       is_shift, is_alt, is_ctrl, is_caps, is_super, is_mod;
    logic                       is_toggle;
    logic                       produce;
    logic                       term_hit;
    logic [10:0]                term_lim;
    logic [7:0]                 map_byte;
    esc_t                       esc;
    win_t                       win;
    result_t [ESC_LEN_MAX-1:0]  tail;
    logic [2:0]                 tail_n;

    assign down      = key_value != 2'd0;
    assign is_shift  = key_code == KEY_LSHIFT || key_code == KEY_RSHIFT;
    assign is_alt    = key_code == KEY_LALT || key_code == KEY_RALT;
    assign is_ctrl   = key_code == KEY_LCTRL || key_code == KEY_RCTRL;
    assign is_caps   = key_code == KEY_CAPS;
    assign is_super  = key_code == KEY_SUPER;
    assign is_mod    = is_shift || is_alt || is_ctrl || is_caps || is_super;
    assign is_toggle = super_reg && key_code == KEY_TAB && !down;
    assign produce   = is_key_event && !is_mod && !is_toggle && !disabled_reg && down;
    assign term_lim  = 11'(term_count) + 11'(KEY_DIGIT1);
    assign term_hit  = key_code >= KEY_DIGIT1 && {1'b0, key_code} < term_lim;
    assign esc       = esc_seq(key_code);
    assign win       = win_action(key_code);

    always_comb
    begin
        map_byte = 8'd0;
        tail     = '0;
        tail_n   = 3'd0;
        if (super_reg)
        begin
            if (win.hit)
            begin
                tail[0].kind = KIND_WIN;
                tail[0].act  = win.act;
                tail[0].shf  = shift_reg;
                tail_n       = 3'd1;
            end
        end
        else if (key_code <= KEY_MAP_LAST)
        begin
            map_byte = shift_reg ? SHIFT_MAP[key_code[5:0]] : PLAIN_MAP[key_code[5:0]];
            if (ctrl_reg && map_byte inside {["a":"z"]})
            begin
                map_byte = map_byte - 8'd96;
            end
            tail[0].kind = KIND_BYTE;
            tail[0].data = map_byte;
            tail_n       = (map_byte != 8'd0) ? 3'd1 : 3'd0;
        end
        else if (key_code == KEY_SPACE)
        begin
            tail[0].kind = KIND_BYTE;
            tail[0].data = SPACE_BYTE;
            tail_n       = 3'd1;
        end
        else
        begin
            for (int i = 0; i < ESC_LEN_MAX; i++)
            begin
                tail[i].kind = KIND_BYTE;
                tail[i].data = esc.bytes[i];
            end
            tail_n = esc.len;
        end
    end

    always_comb
    begin
        burst = '0;
        if (produce)
        begin
            if (alt_reg && term_hit)
            begin
                burst.cnt              = 3'd1;
                burst.entries[0].kind  = KIND_TERM;
                burst.entries[0].term  = 4'(key_code - KEY_DIGIT1);
            end
            else if (alt_reg)
            begin
                burst.cnt              = tail_n + 3'd1;
                burst.entries[0].kind  = KIND_BYTE;
                burst.entries[0].data  = ESC_BYTE;
                for (int i = 1; i < MAX_RESULTS; i++)
                begin
                    burst.entries[i] = tail[i-1];
                end
            end
            else
            begin
                burst.cnt = tail_n;
                for (int i = 0; i < ESC_LEN_MAX; i++)
                begin
                    burst.entries[i] = tail[i];
                end
            end
        end
    end

    always_comb
    begin
        shift_next    = shift_reg;
        alt_next      = alt_reg;
        ctrl_next     = ctrl_reg;
        caps_next     = caps_reg;
        super_next    = super_reg;
        disabled_next = disabled_reg;
        if (fire && is_key_event)
        begin
            if (is_shift)
            begin
                shift_next = down;
            end
            else if (is_alt)
            begin
                alt_next = down;
            end
            else if (is_ctrl)
            begin
                ctrl_next = down;
            end
            else if (is_caps)
            begin
                caps_next = down;
            end
            else if (is_super)
            begin
                super_next = down;
            end
            else if (is_toggle)
            begin
                disabled_next = !disabled_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= 1'b0;
            alt_reg      <= 1'b0;
            ctrl_reg     <= 1'b0;
            caps_reg     <= 1'b0;
            super_reg    <= 1'b0;
            disabled_reg <= 1'b0;
        end
        else
        begin
            shift_reg    <= shift_next;
            alt_reg      <= alt_next;
            ctrl_reg     <= ctrl_next;
            caps_reg     <= caps_next;
            super_reg    <= super_next;
            disabled_reg <= disabled_next;
        end
    end

endmodule

// ===== hw/rtl/ktb_serializer.sv =====
// Result buffer that holds one burst and sends its results one transaction at a time.
module ktb_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  ktb_pkg::burst_t burst,
    output logic            take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic [3:0]      terminal_index,
    output logic [2:0]      window_action,
    output logic            action_shifted,
    output logic            last
);
    import ktb_pkg::*;

    logic [2:0]                cnt_reg, cnt_next;
    result_t [MAX_RESULTS-1:0] buf_reg, buf_next;
    logic                      out_fire;

    assign out_valid      = cnt_reg != 3'd0;
    assign out_fire       = out_valid && out_ready;
    assign take           = cnt_reg == 3'd0 || (cnt_reg == 3'd1 && out_ready);
    assign kind           = buf_reg[0].kind;
    assign out_byte       = buf_reg[0].data;
    assign terminal_index = buf_reg[0].term;
    assign window_action  = buf_reg[0].act;
    assign action_shifted = buf_reg[0].shf;
    assign last           = cnt_reg == 3'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        buf_next = buf_reg;
        if (fire)
        begin
            cnt_next = burst.cnt;
            buf_next = burst.entries;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - 3'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[MAX_RESULTS-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(MAX_RESULTS))
        else $error("result count exceeds burst size");

    a_keep_rest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("remaining results dropped");

    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TERM |-> last)
        else $error("terminal select not final");

    a_win_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WIN |-> last)
        else $error("window command not final");
`endif

endmodule

// ===== hw/rtl/key_event_to_terminal_bytes.sv =====
// Top level: input register, terminal count register, decode and result buffer.
//
// Input channel in_valid/in_ready carries one keyboard event per transaction
// (is_key_event, key_code, key_value). Output channel out_valid/out_ready
// carries the results of each event, one per transaction, with last set on
// the final result of an event. Events that cause no result give nothing.
// Config channel cfg_valid/cfg_ready writes terminal_count from cfg_data;
// cfg_ready is always high.
// An accepted event waits in the input register until the result buffer can take it.
// The result buffer sends one result per cycle while out_ready is high, and
// an event with no result leaves it empty; the next event is decoded in the
// cycle its last result is taken, so bursts follow each other without a gap.
// Reset clears all modifier flags, the disabled flag, both pipeline stages,
// and sets terminal_count to 4.
// When the receiver stalls the result buffer holds its current result, one
// more event waits in the input register, and in_ready drops.
module key_event_to_terminal_bytes (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       is_key_event,
    input  logic [9:0] key_code,
    input  logic [1:0] key_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [3:0] terminal_index,
    output logic [2:0] window_action,
    output logic       action_shifted,
    output logic       last
);
    import ktb_pkg::*;

    logic       in_valid_reg;
    logic       key_reg;
    logic [9:0] code_reg;
    logic [1:0] value_reg;
    logic [3:0] term_count_reg;
    logic       take;
    logic       fire;
    burst_t     burst;

    assign fire      = in_valid_reg && take;
    assign in_ready  = !in_valid_reg || take;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            term_count_reg <= TERM_COUNT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                term_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg   <= is_key_event;
            code_reg  <= key_code;
            value_reg <= key_value;
        end
    end

    ktb_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .is_key_event (key_reg),
        .key_code     (code_reg),
        .key_value    (value_reg),
        .term_count   (term_count_reg),
        .burst        (burst)
    );

    ktb_serializer u_serializer (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .burst          (burst),
        .take           (take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .terminal_index (terminal_index),
        .window_action  (window_action),
        .action_shifted (action_shifted),
        .last           (last)
    );

endmodule
